// ===== hdl/torq_pkg.sv =====
// types and constants shared by the timestamp-ordered request queue
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package torq_pkg;

  localparam int ID_W                = 8;
  localparam int TS_W                = 31;
  localparam int COUNT_W             = 5;
  localparam int DEFAULT_QUEUE_DEPTH = 16;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [TS_W-1:0] ts;
  } entry_t;

  // operation broadcast to every cell
  typedef struct packed {
    logic            ins;
    logic            rem;
    logic [ID_W-1:0] id;
    logic [TS_W-1:0] ts;
  } cell_ctrl_t;

  // what one cell shows its neighbors
  typedef struct packed {
    logic   valid;
    entry_t entry;
    logic   keep;
    logic   hit;
  } cell_link_t;

endpackage
`default_nettype wire

// ===== hdl/timestamp_ordered_request_queue_unit.sv =====
// top level of the timestamp-ordered request queue: chain of torq_cell slots
// plus result register; uses torq_pkg and torq_cell
//
// channel  direction  fields
// in       input      req_type, proc_id, timestamp
// out      output     op_ok, overflow, head_valid, head_id, head_timestamp, entry_count
//
// every cell compares itself to the item at once, so an item updates the
// queue in the cycle it is accepted and its result shows the next cycle
// one item per cycle while out_ready stays high; a held result stalls input
// reset clears every cell's valid bit directly, no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module timestamp_ordered_request_queue_unit #(
  parameter int QUEUE_DEPTH = torq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire                          req_type,
  input  wire  [torq_pkg::ID_W-1:0]    proc_id,
  input  wire  [torq_pkg::TS_W-1:0]    timestamp,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic                         op_ok,
  output logic                         overflow,
  output logic                         head_valid,
  output logic [torq_pkg::ID_W-1:0]    head_id,
  output logic [torq_pkg::TS_W-1:0]    head_timestamp,
  output logic [torq_pkg::COUNT_W-1:0] entry_count
);
  import torq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cell_link_t             links [QUEUE_DEPTH];
  cell_link_t             left_in [QUEUE_DEPTH];
  cell_link_t             right_in [QUEUE_DEPTH];
  cell_ctrl_t             ctrl;
  logic [QUEUE_DEPTH-1:0] valids;
  logic [CW-1:0]          count;
  logic [CW+COUNT_W-1:0]  count_ext;
  logic                   accept;
  logic                   full;
  logic                   found;
  logic                   is_insert;

  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign is_insert = (req_type == REQ_INSERT);
  assign full      = links[QUEUE_DEPTH-1].valid;
  assign found     = links[QUEUE_DEPTH-1].hit;

  assign ctrl.ins = accept && is_insert && !full;
  assign ctrl.rem = accept && (req_type == REQ_REMOVE) && found;
  assign ctrl.id  = proc_id;
  assign ctrl.ts  = timestamp;

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_first
        // head slot sees a left neighbor that is always valid and keeps, never a hit
        assign left_in[g] = '{valid: 1'b1, entry: '0, keep: 1'b1, hit: 1'b0};
      end else begin : g_mid
        assign left_in[g] = links[g-1];
      end
      if (g == QUEUE_DEPTH - 1) begin : g_last
        assign right_in[g] = '0;
      end else begin : g_inner
        assign right_in[g] = links[g+1];
      end
      assign valids[g] = links[g].valid;

      torq_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .ctrl  (ctrl),
        .left  (left_in[g]),
        .right (right_in[g]),
        .link  (links[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.ins) begin
        count <= count + 1'b1;
      end else if (ctrl.rem) begin
        count <= count - 1'b1;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_ok    <= ctrl.ins || ctrl.rem;
      overflow <= is_insert && full;
    end
  end

  // head read straight from the chain, count from its own register; both only move on accept or reset
  assign head_valid     = links[0].valid;
  assign head_id        = links[0].valid ? links[0].entry.id : '0;
  assign head_timestamp = links[0].valid ? links[0].entry.ts : '0;
  assign count_ext      = {{COUNT_W{1'b0}}, count};
  assign entry_count    = count_ext[COUNT_W-1:0];

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(valids) == int'(count))
    else $error("entry count differs from occupied slots");

  a_packed_at_head: assert property (@(posedge clk) disable iff (rst)
    (valids & (valids + 1'b1)) == '0)
    else $error("occupied slots not contiguous from head");

  a_overflow_only_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow) |-> (!op_ok && int'(count) == QUEUE_DEPTH))
    else $error("overflow flagged with room left");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ctrl.ins |=> (int'(count) == int'($past(count)) + 1))
    else $error("insert did not add an entry");

endmodule
`default_nettype wire

// ===== hdl/torq_cell.sv =====
// one slot of the sorted queue chain: holds an entry, compares it to the
// broadcast item and shifts toward or away from the head; uses torq_pkg
`timescale 1ns / 1ps
`default_nettype none
module torq_cell (
  input  wire                     clk,
  input  wire                     rst,
  input  torq_pkg::cell_ctrl_t    ctrl,
  input  torq_pkg::cell_link_t    left,
  input  torq_pkg::cell_link_t    right,
  output torq_pkg::cell_link_t    link
);
  import torq_pkg::*;

  logic   valid;
  entry_t entry;
  logic   lt;
  logic   keep;
  logic   hit;

  // stored entry orders strictly before the new one
  assign lt   = (entry.ts < ctrl.ts) || ((entry.ts == ctrl.ts) && (entry.id < ctrl.id));
  assign keep = valid && lt;
  assign hit  = left.hit || (valid && (entry.id == ctrl.id));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.ins) begin
      valid <= valid || left.valid;
    end else if (ctrl.rem && hit) begin
      valid <= right.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ins && !keep) begin
      if (left.keep) begin
        entry.id <= ctrl.id;
        entry.ts <= ctrl.ts;
      end else begin
        entry <= left.entry;
      end
    end else if (ctrl.rem && hit) begin
      entry <= right.entry;
    end
  end

  assign link.valid = valid;
  assign link.entry = entry;
  assign link.keep  = keep;
  assign link.hit   = hit;

endmodule
`default_nettype wire
